### rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared codes and types of the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_YIELD  = 2'd1;
	localparam logic [1:0] OP_JOIN   = 2'd2;
	localparam logic [1:0] OP_EXIT   = 2'd3;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_FULL    = 3'd1;
	localparam logic [2:0] STAT_SELF    = 3'd2;
	localparam logic [2:0] STAT_JOINED  = 3'd3;
	localparam logic [2:0] STAT_NO_RUN  = 3'd4;

	localparam logic [2:0] ST_UNUSED  = 3'd0;
	localparam logic [2:0] ST_READY   = 3'd1;
	localparam logic [2:0] ST_RUNNING = 3'd2;
	localparam logic [2:0] ST_WAITING = 3'd3;
	localparam logic [2:0] ST_EXITED  = 3'd4;

	typedef struct packed {
		logic        start;
		logic [1:0]  op;
		logic [31:0] exit_value;
	} ctrl_req_t;

	typedef struct packed {
		logic idle;
		logic done;
	} ctrl_rsp_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot;
		logic        woken_valid;
		logic [5:0]  woken_slot;
		logic [31:0] value;
	} result_t;

	typedef struct packed {
		logic       go;
		logic [2:0] code;
	} scan_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic found;
	} scan_rsp_t;

endpackage

### rtl/core/rrts_cmd_if.sv
// ----------------------------------------------------------------------------
// rrts_cmd_if
// Scheduling event channel: valid/ready handshake with op, target, exit value.
// ----------------------------------------------------------------------------
interface rrts_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [5:0]  target;
	logic [31:0] exit_value;

	modport source (output valid, output op, output target, output exit_value, input ready);
	modport sink (input valid, input op, input target, input exit_value, output ready);
endinterface

### rtl/core/rrts_res_if.sv
// ----------------------------------------------------------------------------
// rrts_res_if
// Scheduling result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface rrts_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  slot;
	logic        woken_valid;
	logic [5:0]  woken_slot;
	logic [31:0] value;

	modport source (output valid, output status, output slot, output woken_valid,
		output woken_slot, output value, input ready);
	modport sink (input valid, input status, input slot, input woken_valid,
		input woken_slot, input value, output ready);
endinterface

### rtl/core/round_robin_thread_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_top
// Thread-slot table with round-robin switching on create/yield/join/exit.
// ----------------------------------------------------------------------------
// Takes one scheduling event on cmd and returns one result on res. After
// reset the slot table is cleared one entry per cycle, so cmd.ready stays low
// until the whole table is cleared. The shortest events are a self join and a
// full table; in the longest the block walks the slot-state table
// one entry per cycle through a single scan unit, once to find a free slot or
// the next ready slot, and a second time for the lowest waiting slot when no
// slot is ready. cmd.ready is high only between events; a finished result
// waits in the output register while the next event is taken.
module round_robin_thread_scheduler_top
	import rrts_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	rrts_cmd_if.sink     cmd,
	rrts_res_if.source   res
);

	localparam int IDX_W = $clog2(SLOTS);

	ctrl_req_t        creq;
	ctrl_rsp_t        crsp;
	result_t          cres;
	scan_req_t        sreq;
	scan_rsp_t        srsp;
	logic [IDX_W-1:0] sstart;
	logic [IDX_W-1:0] sidx;
	logic [IDX_W-1:0] saddr;
	logic [2:0]       st_rd;
	logic [IDX_W-1:0] tgt_mod;
	logic             res_free;
	logic             out_vld_q;
	result_t          res_q;

	// target modulo SLOTS by restoring subtraction of constant multiples
	function automatic logic [IDX_W-1:0] tgt_reduce(input logic [5:0] t);
		logic [15:0] r;
		r = 16'(t);
		for (int b = 5; b >= 0; b--) begin
			if (r >= 16'(SLOTS << b)) r = r - 16'(SLOTS << b);
		end
		return IDX_W'(r);
	endfunction

	assign tgt_mod         = tgt_reduce(cmd.target);
	assign cmd.ready       = crsp.idle;
	assign creq.start      = cmd.valid && crsp.idle;
	assign creq.op         = cmd.op;
	assign creq.exit_value = cmd.exit_value;
	assign res_free        = !out_vld_q || res.ready;

	rrts_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (creq),
		.tgt     (tgt_mod),
		.res_free(res_free),
		.rsp     (crsp),
		.res     (cres),
		.sreq    (sreq),
		.sstart  (sstart),
		.srsp    (srsp),
		.sidx    (sidx),
		.saddr   (saddr),
		.st_rd   (st_rd)
	);

	rrts_scan #(
		.SLOTS(SLOTS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sreq),
		.start (sstart),
		.st_rd (st_rd),
		.addr  (saddr),
		.idx   (sidx),
		.rsp   (srsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (crsp.done) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (crsp.done) res_q <= cres;
	end

	assign res.valid       = out_vld_q;
	assign res.status      = res_q.status;
	assign res.slot        = res_q.slot;
	assign res.woken_valid = res_q.woken_valid;
	assign res.woken_slot  = res_q.woken_slot;
	assign res.value       = res_q.value;

endmodule

### rtl/core/rrts_scan.sv
// ----------------------------------------------------------------------------
// rrts_scan
// Shared table scan unit: walks the slot-state table one entry per cycle,
// wrapping, until an entry holds the requested state or all SLOTS are read.
// ----------------------------------------------------------------------------
module rrts_scan
	import rrts_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  scan_req_t                  req,
	input  logic [$clog2(SLOTS)-1:0]   start,
	input  logic [2:0]                 st_rd,
	output logic [$clog2(SLOTS)-1:0]   addr,
	output logic [$clog2(SLOTS)-1:0]   idx,
	output scan_rsp_t                  rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	logic             act_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [2:0]       code_q;
	logic             vld_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             issue;
	logic             hit;
	logic             fin;
	logic [IDX_W-1:0] idx_nxt;

	assign issue   = act_q && (cnt_q != '0);
	assign hit     = vld_s1 && (st_rd == code_q);
	assign fin     = act_q && vld_s1 && (hit || last_s1);
	assign idx_nxt = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;

	assign addr      = idx_q;
	assign idx       = idx_s1;
	assign rsp.busy  = act_q;
	assign rsp.done  = fin;
	assign rsp.found = hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (req.go) begin
			act_q  <= 1'b1;
			cnt_q  <= CNT_W'(SLOTS);
			vld_s1 <= 1'b0;
		end else if (fin) begin
			act_q  <= 1'b0;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (issue) begin
			cnt_q  <= cnt_q - 1'b1;
			vld_s1 <= 1'b1;
		end else begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			idx_q  <= start;
			code_q <= req.code;
		end else if (issue) begin
			idx_q   <= idx_nxt;
			idx_s1  <= idx_q;
			last_s1 <= (cnt_q == CNT_W'(1));
		end
	end

endmodule

### rtl/core/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// Scheduler sequencer: holds the slot tables and runs each event as a short
// series of table reads, writes and scans.
// ----------------------------------------------------------------------------
module rrts_ctrl
	import rrts_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctrl_req_t                  req,
	input  logic [$clog2(SLOTS)-1:0]   tgt,
	input  logic                       res_free,
	output ctrl_rsp_t                  rsp,
	output result_t                    res,
	output scan_req_t                  sreq,
	output logic [$clog2(SLOTS)-1:0]   sstart,
	input  scan_rsp_t                  srsp,
	input  logic [$clog2(SLOTS)-1:0]   sidx,
	input  logic [$clog2(SLOTS)-1:0]   saddr,
	output logic [2:0]                 st_rd
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int LIVE_W = $clog2(SLOTS + 1);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_JCHK   = 4'd3;
	localparam logic [3:0] S_XCHK   = 4'd4;
	localparam logic [3:0] S_SCAN_U = 4'd5;
	localparam logic [3:0] S_YREG   = 4'd6;
	localparam logic [3:0] S_JREG   = 4'd7;
	localparam logic [3:0] S_SCAN_R = 4'd8;
	localparam logic [3:0] S_SCAN_W = 4'd9;
	localparam logic [3:0] S_FIN    = 4'd10;

	logic [2:0]        st_mem [SLOTS];
	logic              jv_mem [SLOTS];
	logic [IDX_W-1:0]  js_mem [SLOTS];
	logic [31:0]       vm_mem [SLOTS];

	logic [3:0]        state_q, state_d;
	logic [IDX_W-1:0]  cur_q, cur_d;
	logic [LIVE_W-1:0] live_q, live_d;
	logic              main_q, main_d;
	logic [IDX_W-1:0]  clr_q;

	logic [1:0]        op_q;
	logic [IDX_W-1:0]  tgt_q;
	logic [31:0]       xval_q;
	logic [2:0]        status_q, status_d;
	logic              wv_q, wv_d;
	logic [IDX_W-1:0]  ws_q, ws_d;
	logic [31:0]       val_q, val_d;
	logic [IDX_W-1:0]  u_q, u_d;

	logic              st_we;
	logic [IDX_W-1:0]  st_wa;
	logic [2:0]        st_wd;
	logic              jv_we;
	logic [IDX_W-1:0]  jv_wa;
	logic              jv_wd;
	logic              js_we;
	logic [IDX_W-1:0]  js_wd;
	logic              vm_we;

	logic [IDX_W-1:0]  ctrl_raddr;
	logic [IDX_W-1:0]  st_raddr;
	logic              jv_rd;
	logic [IDX_W-1:0]  js_rd;
	logic [31:0]       vm_rd;
	logic [IDX_W-1:0]  cur_inc;
	logic [IDX_W-1:0]  slot_sel;

	assign cur_inc    = (cur_q == IDX_W'(SLOTS - 1)) ? '0 : cur_q + 1'b1;
	assign ctrl_raddr = (op_q == OP_EXIT) ? cur_q : tgt_q;
	assign st_raddr   = srsp.busy ? saddr : ctrl_raddr;

	// table storage
	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_wa] <= st_wd;
		st_rd <= st_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (jv_we) jv_mem[jv_wa] <= jv_wd;
		jv_rd <= jv_mem[ctrl_raddr];
	end

	always_ff @(posedge clk) begin
		if (js_we) js_mem[tgt_q] <= js_wd;
		js_rd <= js_mem[ctrl_raddr];
	end

	always_ff @(posedge clk) begin
		if (vm_we) vm_mem[cur_q] <= xval_q;
		vm_rd <= vm_mem[ctrl_raddr];
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		live_d    = live_q;
		main_d    = main_q;
		status_d  = status_q;
		wv_d      = wv_q;
		ws_d      = ws_q;
		val_d     = val_q;
		u_d       = u_q;
		st_we     = 1'b0;
		st_wa     = cur_q;
		st_wd     = ST_UNUSED;
		jv_we     = 1'b0;
		jv_wa     = tgt_q;
		jv_wd     = 1'b0;
		js_we     = 1'b0;
		js_wd     = cur_q;
		vm_we     = 1'b0;
		sreq.go   = 1'b0;
		sreq.code = ST_READY;
		sstart    = cur_inc;
		rsp.idle  = (state_q == S_IDLE);
		rsp.done  = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				st_we = 1'b1;
				st_wa = clr_q;
				jv_we = 1'b1;
				jv_wa = clr_q;
				if (clr_q == IDX_W'(SLOTS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req.start) begin
					status_d = STAT_OK;
					wv_d     = 1'b0;
					ws_d     = '0;
					val_d    = '0;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (op_q)
					OP_CREATE: begin
						if (live_q >= LIVE_W'(SLOTS)) begin
							status_d = STAT_FULL;
							state_d  = S_FIN;
						end else begin
							sreq.go   = 1'b1;
							sreq.code = ST_UNUSED;
							sstart    = cur_q;
							state_d   = S_SCAN_U;
						end
					end
					OP_YIELD: begin
						if (!main_q) begin
							sreq.go   = 1'b1;
							sreq.code = ST_UNUSED;
							sstart    = cur_q;
							state_d   = S_SCAN_U;
						end else begin
							st_we   = 1'b1;
							st_wd   = ST_READY;
							sreq.go = 1'b1;
							state_d = S_SCAN_R;
						end
					end
					OP_JOIN: begin
						if (!main_q) begin
							sreq.go   = 1'b1;
							sreq.code = ST_UNUSED;
							sstart    = cur_q;
							state_d   = S_SCAN_U;
						end else if (cur_q == tgt_q) begin
							status_d = STAT_SELF;
							state_d  = S_FIN;
						end else begin
							state_d = S_JCHK;
						end
					end
					OP_EXIT: begin
						st_we   = 1'b1;
						st_wd   = ST_EXITED;
						vm_we   = 1'b1;
						val_d   = xval_q;
						state_d = S_XCHK;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_JCHK: begin
				if (jv_rd) begin
					status_d = STAT_JOINED;
					state_d  = S_FIN;
				end else if (st_rd == ST_EXITED) begin
					st_we   = 1'b1;
					st_wa   = tgt_q;
					st_wd   = ST_UNUSED;
					jv_we   = 1'b1;
					if (live_q != '0) live_d = live_q - 1'b1;
					val_d   = vm_rd;
					state_d = S_FIN;
				end else begin
					st_we   = 1'b1;
					st_wd   = ST_WAITING;
					jv_we   = 1'b1;
					jv_wd   = 1'b1;
					js_we   = 1'b1;
					sreq.go = 1'b1;
					state_d = S_SCAN_R;
				end
			end
			S_XCHK: begin
				if (jv_rd) begin
					st_we = 1'b1;
					st_wa = js_rd;
					st_wd = ST_READY;
					wv_d  = 1'b1;
					ws_d  = js_rd;
				end
				sreq.go = 1'b1;
				state_d = S_SCAN_R;
			end
			S_SCAN_U: begin
				if (srsp.done) begin
					u_d = sidx;
					if (!srsp.found) begin
						status_d = STAT_FULL;
						state_d  = S_FIN;
					end else begin
						case (op_q)
							OP_CREATE: begin
								st_we   = 1'b1;
								st_wa   = sidx;
								st_wd   = ST_READY;
								live_d  = live_q + 1'b1;
								state_d = S_FIN;
							end
							OP_YIELD: begin
								st_we   = 1'b1;
								st_wa   = sidx;
								st_wd   = ST_READY;
								main_d  = 1'b1;
								state_d = S_YREG;
							end
							OP_JOIN: begin
								st_we   = 1'b1;
								st_wa   = tgt_q;
								st_wd   = ST_RUNNING;
								jv_we   = 1'b1;
								jv_wd   = 1'b1;
								js_we   = 1'b1;
								js_wd   = sidx;
								cur_d   = tgt_q;
								main_d  = 1'b1;
								state_d = S_JREG;
							end
							default: state_d = S_FIN;
						endcase
					end
				end
			end
			S_YREG: begin
				st_we   = 1'b1;
				st_wd   = ST_RUNNING;
				state_d = S_FIN;
			end
			S_JREG: begin
				st_we   = 1'b1;
				st_wa   = u_q;
				st_wd   = ST_WAITING;
				state_d = S_FIN;
			end
			S_SCAN_R: begin
				if (srsp.done) begin
					if (srsp.found) begin
						cur_d   = sidx;
						st_we   = 1'b1;
						st_wa   = sidx;
						st_wd   = ST_RUNNING;
						state_d = S_FIN;
					end else begin
						sreq.go   = 1'b1;
						sreq.code = ST_WAITING;
						sstart    = '0;
						state_d   = S_SCAN_W;
					end
				end
			end
			S_SCAN_W: begin
				if (srsp.done) begin
					if (srsp.found) begin
						cur_d   = sidx;
						st_we   = 1'b1;
						st_wa   = sidx;
						st_wd   = ST_RUNNING;
					end else begin
						status_d = STAT_NO_RUN;
					end
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (res_free) begin
					rsp.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cur_q   <= '0;
			live_q  <= '0;
			main_q  <= 1'b0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			live_q  <= live_d;
			main_q  <= main_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.start) begin
			op_q   <= req.op;
			tgt_q  <= tgt;
			xval_q <= req.exit_value;
		end
		status_q <= status_d;
		wv_q     <= wv_d;
		ws_q     <= ws_d;
		val_q    <= val_d;
		u_q      <= u_d;
	end

	assign slot_sel = (op_q == OP_CREATE && status_q == STAT_OK) ? u_q : cur_q;

	assign res.status      = status_q;
	assign res.slot        = 6'(slot_sel);
	assign res.woken_valid = wv_q;
	assign res.woken_slot  = 6'(ws_q);
	assign res.value       = val_q;

endmodule
